>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the reply checker.
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MBRC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbrc: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define MBRC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbrc: next-cycle check failed");

`endif

>>> hw/rtl/mbrc_pkg.sv
// Types and fixed constants of the Modbus RTU reply checker.
// No dependencies; every other file of the block but assert_macros.svh imports it.
`default_nettype none

package mbrc_pkg;

  localparam int BYTE_W         = 8;
  localparam int STATUS_W       = 3;
  localparam int REG_INDEX_W    = 3;
  localparam int REG_VALUE_W    = 16;
  localparam int CRC_W          = 16;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 8;
  localparam int WORD_COUNT_W   = 4;
  localparam int WORD_COUNT_MAX = 15;

  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
  localparam logic [BYTE_W-1:0] FC_READ  = 8'h03;
  localparam logic [BYTE_W-1:0] FC_WRITE = 8'h06;

  // Frame layout
  localparam int ECHO_LEN      = 8;
  localparam int READ_OVERHEAD = 5;
  localparam int CRC_BYTES     = 2;
  localparam int POS_ADDR      = 0;
  localparam int POS_FUNC      = 1;
  localparam int POS_COUNT     = 2;
  localparam int POS_DATA      = 3;
  localparam int POS_ECHO      = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_ADDR  = 3'd2,
    ST_FUNC  = 3'd3,
    ST_COUNT = 3'd4,
    ST_ECHO  = 3'd5,
    ST_CRC   = 3'd6
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SLAVE_ADDRESS = 2'd0,
    CFG_WORD_COUNT    = 2'd1,
    CFG_FRAME_KIND    = 2'd2,
    CFG_ECHO_VALUE    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic clear;
    logic start;
  } crc_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/mbrc_rx_if.sv
// Receive byte channel: valid/ready with one frame byte and its end flag.
// Depends on mbrc_pkg for field widths.
`default_nettype none

interface mbrc_rx_if import mbrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mbrc_result_if.sv
// Result channel: valid/ready with status, register index, word and last flag.
// Depends on mbrc_pkg for field widths.
`default_nettype none

interface mbrc_result_if import mbrc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [REG_INDEX_W-1:0] reg_index;
  logic [REG_VALUE_W-1:0] reg_value;
  logic                   last;

  modport source (output valid, output status, output reg_index, output reg_value,
                  output last, input ready);
  modport sink   (input valid, input status, input reg_index, input reg_value,
                  input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mbrc_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on mbrc_pkg for field widths.
`default_nettype none

interface mbrc_cfg_if import mbrc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/modbus_rtu_response_checker.sv
// Modbus RTU reply checker. Bytes of one reply come in on rx, each with a
// frame_end flag; configuration (slave address, word count, frame kind, echo
// value) must be written over cfg only while no frame is in flight; the
// block does not enforce this, and cfg is always ready. Each byte inside the
// expected length is checked against the header, run through a bit-serial
// CRC-16 (reflected 0xA001, start 0xFFFF) or taken as a CRC byte; data bytes
// of a read reply pair into big-endian words held in a small RAM. Bytes past
// the expected length are dropped. On frame end the block reports one status
// transaction, or for a good read reply one transaction per register word
// with last on the final one. A byte covered by the CRC is accepted, shifted
// bit by bit through the CRC engine, and the block waits to see the engine
// idle; a CRC byte or an ignored byte is accepted without leaving idle. Frame
// end adds a verdict state, then a RAM read and an output load state per
// word of a good read reply, else one output state; a load waits while the
// result sink stalls. The output register lets the next frame's bytes be
// accepted while the final result still waits to be taken. Depends on
// mbrc_pkg, the three channel interfaces, mbrc_crc_serial and mbrc_word_buf.
`default_nettype none

module modbus_rtu_response_checker import mbrc_pkg::*; #(
  parameter int MAX_WORDS = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  mbrc_rx_if.sink       rx,
  mbrc_result_if.source result,
  mbrc_cfg_if.sink      cfg
);

  // The word_count register cannot ask for more than WORD_COUNT_MAX words.
  localparam int WORD_CAP = (MAX_WORDS < WORD_COUNT_MAX) ? MAX_WORDS : WORD_COUNT_MAX;
  localparam int READ_MAX = READ_OVERHEAD + 2 * WORD_CAP;
  localparam int MAX_LEN  = (READ_MAX > ECHO_LEN) ? READ_MAX : ECHO_LEN;
  localparam int POS_W    = $clog2(MAX_LEN + 1);
  localparam int WCNT_W   = $clog2(WORD_CAP + 1);
  localparam int IDX_W    = (WORD_CAP > 1) ? $clog2(WORD_CAP) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_FINISH,
    S_SINGLE,
    S_READ,
    S_WORD
  } state_t;

  // Configuration registers
  logic [BYTE_W-1:0]       slave_address;
  logic [WORD_COUNT_W-1:0] word_count;
  logic                    frame_kind;
  logic [BYTE_W-1:0]       echo_value;

  // Frame state
  state_t                  state;
  logic [POS_W-1:0]        byte_position;
  status_t                 first_error;
  logic [CRC_W-1:0]        received_crc;
  logic [BYTE_W-1:0]       pending_high_byte;
  logic                    end_flag;
  status_t                 verdict;
  logic [WCNT_W-1:0]       emit_idx;

  // Output register
  logic                    out_valid;
  status_t                 out_status;
  logic [REG_INDEX_W-1:0]  out_index;
  logic [REG_VALUE_W-1:0]  out_value;
  logic                    out_last;
  logic                    out_load;

  // Derived frame geometry and per-byte decode
  logic [WORD_COUNT_W-1:0] wc_clamped;
  logic [WCNT_W-1:0]       words;
  logic [POS_W-1:0]        twice_words;
  logic [POS_W-1:0]        frame_len;
  logic [POS_W-1:0]        crc_end;
  logic [POS_W-1:0]        data_end;
  logic [POS_W-1:0]        data_off;
  logic                    in_frame;
  logic                    in_data;
  logic [BYTE_W-1:0]       count_expected;
  logic [BYTE_W-1:0]       func_expected;
  status_t                 hdr_err;
  status_t                 finish_status;
  logic                    rx_fire;
  logic                    out_free;
  logic                    emit_last;

  crc_ctrl_t               crc_ctrl;
  logic [CRC_W-1:0]        crc_value;
  logic                    crc_busy;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [REG_VALUE_W-1:0]  rd_data;

  assign rx.ready  = (state == S_IDLE);
  assign rx_fire   = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;
  assign out_free  = !out_valid || result.ready;
  assign out_load  = out_free && ((state == S_SINGLE) || (state == S_WORD));

  assign result.valid     = out_valid;
  assign result.status    = out_status;
  assign result.reg_index = out_index;
  assign result.reg_value = out_value;
  assign result.last      = out_last;

  always_comb begin
    // Zero words acts as one; anything above the store depth acts as the depth.
    if (word_count == '0) begin
      wc_clamped = WORD_COUNT_W'(1);
    end else if (word_count > WORD_COUNT_W'(WORD_CAP)) begin
      wc_clamped = WORD_COUNT_W'(WORD_CAP);
    end else begin
      wc_clamped = word_count;
    end
    words          = WCNT_W'(wc_clamped);
    twice_words    = POS_W'({words, 1'b0});
    count_expected = BYTE_W'({words, 1'b0});
    func_expected  = frame_kind ? FC_WRITE : FC_READ;
    frame_len      = frame_kind ? POS_W'(ECHO_LEN) : (POS_W'(READ_OVERHEAD) + twice_words);
    crc_end        = frame_len - POS_W'(CRC_BYTES);
    data_end       = POS_W'(POS_DATA) + twice_words;
    data_off       = byte_position - POS_W'(POS_DATA);
    in_frame       = byte_position < frame_len;
    in_data        = !frame_kind && (byte_position >= POS_W'(POS_DATA))
                     && (byte_position < data_end);
    wr_addr        = IDX_W'(data_off >> 1);
    emit_last      = (emit_idx == (words - WCNT_W'(1)));

    hdr_err = ST_OK;
    if (byte_position == POS_W'(POS_ADDR)) begin
      if (rx.rx_byte != slave_address) hdr_err = ST_ADDR;
    end else if (byte_position == POS_W'(POS_FUNC)) begin
      if (rx.rx_byte != func_expected) hdr_err = ST_FUNC;
    end else if (!frame_kind && byte_position == POS_W'(POS_COUNT)) begin
      if (rx.rx_byte != count_expected) hdr_err = ST_COUNT;
    end else if (frame_kind && byte_position == POS_W'(POS_ECHO)) begin
      if (rx.rx_byte != echo_value) hdr_err = ST_ECHO;
    end

    // Header error beats short frame, short frame beats CRC mismatch.
    finish_status = first_error;
    if (finish_status == ST_OK && byte_position < frame_len) begin
      finish_status = ST_SHORT;
    end
    if (finish_status == ST_OK && crc_value != received_crc) begin
      finish_status = ST_CRC;
    end

    crc_ctrl.start = rx_fire && in_frame && (byte_position < crc_end);
    crc_ctrl.clear = (state == S_FINISH);
    wr_en          = rx_fire && in_frame && in_data && data_off[0];
  end

  // The user must make configuration writes land only while idle; the block has no guard here.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      word_count    <= 4'd7;
      frame_kind    <= 1'b0;
      echo_value    <= 8'd0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_SLAVE_ADDRESS: slave_address <= cfg.data;
        CFG_WORD_COUNT:    word_count    <= cfg.data[WORD_COUNT_W-1:0];
        CFG_FRAME_KIND:    frame_kind    <= cfg.data[0];
        CFG_ECHO_VALUE:    echo_value    <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      byte_position     <= '0;
      first_error       <= ST_OK;
      received_crc      <= '0;
      pending_high_byte <= '0;
      end_flag          <= 1'b0;
      verdict           <= ST_OK;
      emit_idx          <= '0;
      out_valid         <= 1'b0;
    end else begin
      // Load a new result, or drop the current one once taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (rx_fire) begin
            end_flag <= rx.frame_end;
            if (in_frame) begin
              if (first_error == ST_OK) begin
                first_error <= hdr_err;
              end
              if (in_data && !data_off[0]) begin
                pending_high_byte <= rx.rx_byte;
              end
              // CRC bytes arrive low byte first
              if (byte_position == crc_end) begin
                received_crc[7:0] <= rx.rx_byte;
              end else if (byte_position > crc_end) begin
                received_crc[15:8] <= rx.rx_byte;
              end
              byte_position <= byte_position + POS_W'(1);
            end
            if (crc_ctrl.start) begin
              state <= S_CRC;
            end else if (rx.frame_end) begin
              state <= S_FINISH;
            end
          end
        end
        S_CRC: begin
          // Hold until the serial engine has shifted all eight bits
          if (!crc_busy) begin
            state <= end_flag ? S_FINISH : S_IDLE;
          end
        end
        S_FINISH: begin
          verdict           <= finish_status;
          byte_position     <= '0;
          first_error       <= ST_OK;
          received_crc      <= '0;
          pending_high_byte <= '0;
          emit_idx          <= '0;
          if (finish_status == ST_OK && !frame_kind) begin
            state <= S_READ;
          end else begin
            state <= S_SINGLE;
          end
        end
        S_SINGLE: begin
          if (out_free) begin
            out_status <= verdict;
            out_index  <= '0;
            out_value  <= '0;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_WORD;
        end
        S_WORD: begin
          if (out_free) begin
            out_status <= ST_OK;
            out_index  <= REG_INDEX_W'(emit_idx);
            out_value  <= rd_data;
            out_last   <= emit_last;
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + WCNT_W'(1);
              state    <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mbrc_crc_serial u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .data (rx.rx_byte),
    .crc  (crc_value),
    .busy (crc_busy)
  );

  mbrc_word_buf #(
    .DEPTH (WORD_CAP),
    .AW    (IDX_W)
  ) u_words (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({pending_high_byte, rx.rx_byte}),
    .rd_en   (state == S_READ),
    .rd_addr (IDX_W'(emit_idx)),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

>>> hw/rtl/mbrc_crc_serial.sv
// Bit-serial CRC-16 engine (reflected polynomial), one data bit per clock.
// Depends on mbrc_pkg for the polynomial, start value and control struct.
`default_nettype none

module mbrc_crc_serial import mbrc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire crc_ctrl_t         ctrl,
  input  wire logic [BYTE_W-1:0] data,
  output logic      [CRC_W-1:0]  crc,
  output logic                   busy
);

  logic [BYTE_W-1:0] shreg;
  logic [2:0]        bit_cnt;
  logic [CRC_W-1:0]  crc_next;
  logic              feedback;

  // LSB first: feedback is the outgoing CRC bit against the incoming data bit
  always_comb begin
    feedback = crc[0] ^ shreg[0];
    crc_next = (crc >> 1) ^ (feedback ? CRC_POLY : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc     <= CRC_INIT;
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (ctrl.clear) begin
      crc     <= CRC_INIT;
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (ctrl.start) begin
      shreg   <= data;
      busy    <= 1'b1;
      bit_cnt <= '0;
    end else if (busy) begin
      crc     <= crc_next;
      shreg   <= shreg >> 1;
      bit_cnt <= bit_cnt + 3'd1;
      if (bit_cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mbrc_word_buf.sv
// Register word store of one read reply: one write port, one registered read.
// Depends on mbrc_pkg for the word width.
`default_nettype none

module mbrc_word_buf import mbrc_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire logic [REG_VALUE_W-1:0] wr_data,
  input  wire logic                   rd_en,
  input  wire logic [AW-1:0]          rd_addr,
  output logic      [REG_VALUE_W-1:0] rd_data
);

  logic [REG_VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mbrc_checker.sv
// Port-level checks of the reply checker, bound onto the top level.
// Depends on mbrc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module mbrc_checker import mbrc_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   rx_ready,
  input wire logic                   res_valid,
  input wire logic                   res_ready,
  input wire logic [STATUS_W-1:0]    res_status,
  input wire logic [REG_INDEX_W-1:0] res_index,
  input wire logic [REG_VALUE_W-1:0] res_value,
  input wire logic                   res_last
);

  // A stalled result holds still
  `MBRC_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready,
    res_valid && $stable(res_status) && $stable(res_index) && $stable(res_value) && $stable(res_last))

  // A failed frame reports one bare result
  `MBRC_ASSERT_IMP(a_err_shape, clk, rst, res_valid && (res_status != ST_OK),
    res_last && (res_index == '0) && (res_value == '0))

  // No bytes taken while a word stream is still going out
  `MBRC_ASSERT_IMP(a_no_rx_mid_stream, clk, rst, res_valid && res_ready && !res_last,
    !rx_ready)

endmodule

bind modbus_rtu_response_checker mbrc_checker u_mbrc_checker (
  .clk        (clk),
  .rst        (rst),
  .rx_ready   (rx.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_status (result.status),
  .res_index  (result.reg_index),
  .res_value  (result.reg_value),
  .res_last   (result.last)
);

`default_nettype wire

>>> tb/modbus_rtu_response_checker_test.sv
// Self-checking bench for the Modbus RTU reply checker: frames in, verdicts and words out.
// Depends on mbrc_pkg, the rx/result/cfg channel interfaces and the checker RTL.
`default_nettype none

module modbus_rtu_response_checker_test;
  import mbrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WORDS     = 8;
  localparam int RANDOM_BYTES  = 440;
  // Leave room for a CRC-covered byte and the verdict after it to finish.
  localparam int SETTLE_CYCLES = 30;

  typedef logic [BYTE_W-1:0] octet_t;
  typedef octet_t octets_t[$];

  typedef struct packed {
    octet_t data;
    logic   fe;
  } rx_item_t;

  typedef struct packed {
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  typedef struct packed {
    status_t                status;
    logic [REG_INDEX_W-1:0] index;
    logic [REG_VALUE_W-1:0] value;
    logic                   last;
  } reg_result_t;

  // Kinds of frame the random part builds.
  typedef enum int {
    FR_GOOD,
    FR_BAD_ADDR,
    FR_BAD_FUNC,
    FR_BAD_COUNT,
    FR_BAD_ECHO,
    FR_BAD_CRC,
    FR_SHORT,
    FR_TRAILING,
    FR_NOISE
  } frame_flaw_t;

  logic clk;
  logic rst;

  mbrc_rx_if     rx();
  mbrc_result_if result();
  mbrc_cfg_if    cfg();

  modbus_rtu_response_checker #(.MAX_WORDS(MAX_WORDS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .result (result),
    .cfg    (cfg)
  );

  always #6 clk = ~clk;

  // Pending transactions for the two input channels.
  rx_item_t   byte_queue[$];
  reg_write_t reg_writes[$];
  // Words and verdicts the checker still owes us, oldest first.
  reg_result_t awaited[$];

  int rx_todo;
  int cfg_todo;
  int errors;
  int frames_sent;
  int bytes_sent;
  int results_seen;
  int settings_used;

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  // Configuration the stimulus is built for.
  octet_t     gen_addr;
  logic [3:0] gen_wc;
  logic       gen_kind;
  octet_t     gen_echo;

  // Predictor copy of the configuration, updated on each register write transaction.
  octet_t     exp_addr;
  logic [3:0] exp_wc;
  logic       exp_kind;
  octet_t     exp_echo;

  // Predictor copy of the frame state.
  int unsigned            frame_pos;
  logic [CRC_W-1:0]       frame_crc;
  status_t                frame_err;
  logic [CRC_W-1:0]       tail_crc;
  octet_t                 high_half;
  logic [REG_VALUE_W-1:0] word_copy[MAX_WORDS];

  rx_item_t   next_item;
  reg_write_t next_write;

  // ---------------------------------------------------------------------------
  // Prediction helpers
  // ---------------------------------------------------------------------------

  // Word count as the checker uses it: zero acts as one, large values clamp.
  function automatic int unsigned eff_words(logic [3:0] wc);
    int unsigned w;
    w = wc;
    if (w < 1) w = 1;
    if (w > MAX_WORDS) w = MAX_WORDS;
    return w;
  endfunction

  // One byte through the reflected CRC-16.
  function automatic logic [CRC_W-1:0] crc16_update(logic [CRC_W-1:0] c, octet_t b);
    logic [CRC_W-1:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] crc_of(octets_t f);
    logic [CRC_W-1:0] c;
    c = CRC_INIT;
    foreach (f[i]) c = crc16_update(c, f[i]);
    return c;
  endfunction

  // Keep only the first header error of the frame.
  task automatic note_error(status_t code);
    if (frame_err == ST_OK) frame_err = code;
  endtask

  task automatic clear_frame();
    frame_pos = 0;
    frame_crc = CRC_INIT;
    frame_err = ST_OK;
    tail_crc  = '0;
    high_half = '0;
  endtask

  // Advance the predicted frame state by one accepted byte; on frame end
  // queue the verdict, or one transaction per word for a good read reply.
  task automatic judge_byte(octet_t b, logic fe);
    int unsigned words;
    int unsigned len;
    int unsigned off;
    logic        echo;
    status_t     st;
    reg_result_t r;
    echo  = exp_kind;
    words = eff_words(exp_wc);
    len   = echo ? ECHO_LEN : READ_OVERHEAD + 2 * words;
    if (frame_pos < len) begin
      if (frame_pos == POS_ADDR) begin
        if (b != exp_addr) note_error(ST_ADDR);
      end else if (frame_pos == POS_FUNC) begin
        if (b != (echo ? FC_WRITE : FC_READ)) note_error(ST_FUNC);
      end else if (!echo && frame_pos == POS_COUNT) begin
        if (b != 2 * words) note_error(ST_COUNT);
      end else if (echo && frame_pos == POS_ECHO) begin
        if (b != exp_echo) note_error(ST_ECHO);
      end
      // Data bytes pair up high byte first.
      if (!echo && frame_pos >= POS_DATA && frame_pos < POS_DATA + 2 * words) begin
        off = frame_pos - POS_DATA;
        if (off % 2 == 0) high_half = b;
        else word_copy[off / 2] = {high_half, b};
      end
      if (frame_pos < len - CRC_BYTES) frame_crc = crc16_update(frame_crc, b);
      else if (frame_pos == len - CRC_BYTES) tail_crc[7:0] = b;
      else tail_crc[15:8] = b;
      frame_pos++;
    end
    if (fe) begin
      // Header error beats short, short beats CRC mismatch.
      st = frame_err;
      if (st == ST_OK && frame_pos < len) st = ST_SHORT;
      if (st == ST_OK && frame_crc != tail_crc) st = ST_CRC;
      if (st == ST_OK && !echo) begin
        for (int unsigned i = 0; i < words; i++) begin
          r.status = ST_OK;
          r.index  = i[REG_INDEX_W-1:0];
          r.value  = word_copy[i];
          r.last   = (i + 1 == words);
          awaited.push_back(r);
        end
      end else begin
        r.status = st;
        r.index  = '0;
        r.value  = '0;
        r.last   = 1'b1;
        awaited.push_back(r);
      end
      clear_frame();
    end
  endtask

  task automatic report(string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Compare one result transaction with the oldest expectation, field by field.
  task automatic check_result();
    reg_result_t want;
    results_seen++;
    if (awaited.size() == 0) begin
      report($sformatf("result with nothing expected: status %0d index %0d value %h last %b",
                       result.status, result.reg_index, result.reg_value, result.last));
    end else begin
      want = awaited.pop_front();
      if (result.status !== want.status)
        report($sformatf("status got %0d want %0d", result.status, want.status));
      if (result.reg_index !== want.index)
        report($sformatf("reg_index got %0d want %0d", result.reg_index, want.index));
      if (result.reg_value !== want.value)
        report($sformatf("reg_value got %h want %h", result.reg_value, want.value));
      if (result.last !== want.last)
        report($sformatf("last got %b want %b", result.last, want.last));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers and monitor
  // ---------------------------------------------------------------------------

  // Byte driver: advance only once the current transaction is taken; hold
  // valid high across back-to-back bytes.
  always @(posedge clk) begin
    if (rst) begin
      rx.valid <= 1'b0;
    end else if (!rx.valid || rx.ready) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_item = byte_queue.pop_front();
        rx.valid     <= 1'b1;
        rx.rx_byte   <= next_item.data;
        rx.frame_end <= next_item.fe;
      end else begin
        rx.valid <= 1'b0;
      end
    end
  end

  // Register write driver, same scheme.
  always @(posedge clk) begin
    if (rst) begin
      cfg.valid <= 1'b0;
    end else if (!cfg.valid || cfg.ready) begin
      if (reg_writes.size() != 0) begin
        next_write = reg_writes.pop_front();
        cfg.valid <= 1'b1;
        cfg.index <= next_write.index;
        cfg.data  <= next_write.data;
      end else begin
        cfg.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: sample all handshakes at the edge, then predict and check.
  always @(posedge clk) begin
    if (!rst) begin
      if (result.valid && result.ready) check_result();
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_SLAVE_ADDRESS: exp_addr = cfg.data;
          CFG_WORD_COUNT:    exp_wc   = cfg.data[3:0];
          CFG_FRAME_KIND:    exp_kind = cfg.data[0];
          CFG_ECHO_VALUE:    exp_echo = cfg.data;
          default: ;
        endcase
        cfg_todo--;
      end
      if (rx.valid && rx.ready) begin
        judge_byte(rx.rx_byte, rx.frame_end);
        rx_todo--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic octet_t flip_mask();
    return octet_t'($urandom_range(1, 255));
  endfunction

  // Queue a frame's bytes, frame_end on the final one.
  task automatic queue_frame(input octets_t f);
    rx_item_t it;
    for (int i = 0; i < f.size(); i++) begin
      it.data = f[i];
      it.fe   = (i == f.size() - 1);
      byte_queue.push_back(it);
    end
    rx_todo     += f.size();
    bytes_sent  += f.size();
    frames_sent++;
  endtask

  // Build a frame for the current configuration, then damage it as asked.
  task automatic make_frame(frame_flaw_t flaw);
    octets_t          f;
    int unsigned      words;
    int unsigned      cut;
    int unsigned      extra;
    logic [CRC_W-1:0] c;
    words = eff_words(gen_wc);
    if (flaw == FR_NOISE) begin
      repeat ($urandom_range(1, 24)) f.push_back(octet_t'($urandom));
      queue_frame(f);
      return;
    end
    f.push_back(gen_addr);
    if (gen_kind) begin
      f.push_back(FC_WRITE);
      repeat (3) f.push_back(octet_t'($urandom));
      f.push_back(gen_echo);
    end else begin
      f.push_back(FC_READ);
      f.push_back(octet_t'(2 * words));
      repeat (2 * words) f.push_back(octet_t'($urandom));
    end
    case (flaw)
      FR_BAD_ADDR: f[POS_ADDR] ^= flip_mask();
      FR_BAD_FUNC: f[POS_FUNC] ^= flip_mask();
      // The count byte is only checked in read mode, the echo byte only in echo mode.
      FR_BAD_COUNT, FR_BAD_ECHO: begin
        if (gen_kind) f[POS_ECHO] ^= flip_mask();
        else f[POS_COUNT] ^= flip_mask();
      end
      default: ;
    endcase
    // Now and then stack a second header error to exercise the priority.
    if (flaw != FR_GOOD && $urandom_range(3) == 0) f[$urandom_range(0, 2)] ^= flip_mask();
    c = crc_of(f);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    if (flaw == FR_BAD_CRC) f[f.size() - 1 - $urandom_range(0, 2)] ^= flip_mask();
    if (flaw == FR_SHORT) begin
      cut = $urandom_range(1, f.size() - 1);
      while (f.size() > cut) void'(f.pop_back());
    end
    if (flaw == FR_TRAILING) begin
      // Trailing bytes sit past the expected length and must be dropped.
      extra = $urandom_range(1, 5);
      repeat (extra) f.push_back(octet_t'($urandom));
    end
    queue_frame(f);
  endtask

  // Write all four registers and wait until every write transaction is taken.
  task automatic configure(octet_t a, logic [3:0] wc, logic k, octet_t ev);
    reg_write_t w;
    gen_addr = a;
    gen_wc   = wc;
    gen_kind = k;
    gen_echo = ev;
    w.index = CFG_SLAVE_ADDRESS; w.data = a;              reg_writes.push_back(w);
    w.index = CFG_WORD_COUNT;    w.data = {4'h0, wc};     reg_writes.push_back(w);
    w.index = CFG_FRAME_KIND;    w.data = {7'h00, k};     reg_writes.push_back(w);
    w.index = CFG_ECHO_VALUE;    w.data = ev;             reg_writes.push_back(w);
    cfg_todo += 4;
    settings_used++;
    while (cfg_todo != 0) @(posedge clk);
  endtask

  // Drain: all bytes taken, all results seen, then let the checker go quiet.
  task automatic settle();
    while (rx_todo != 0) @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Safety net against a hung handshake or a missing result.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    octets_t          f;
    logic [CRC_W-1:0] c;
    int               phase;
    int               first_bytes;
    frame_flaw_t      flaw;

    clk = 1'b0;
    rst = 1'b1;
    rx.valid      = 1'b0;
    rx.rx_byte    = '0;
    rx.frame_end  = 1'b0;
    result.ready  = 1'b0;
    cfg.valid     = 1'b0;
    cfg.index     = CFG_SLAVE_ADDRESS;
    cfg.data      = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    rx_todo = 0; cfg_todo = 0; errors = 0;
    frames_sent = 0; bytes_sent = 0; results_seen = 0; settings_used = 0;

    // Reset values of the registers and the frame state.
    gen_addr = 8'h01; gen_wc = 4'd7; gen_kind = 1'b0; gen_echo = 8'h00;
    exp_addr = 8'h01; exp_wc = 4'd7; exp_kind = 1'b0; exp_echo = 8'h00;
    clear_frame();
    foreach (word_copy[i]) word_copy[i] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: one-word read replies at the address extreme.
    configure(8'hFF, 4'd1, 1'b0, 8'h00);
    // Good reply with data at both byte extremes.
    f = {8'hFF, FC_READ, 8'h02, 8'hFF, 8'h00};
    c = crc_of(f); f.push_back(c[7:0]); f.push_back(c[15:8]);
    queue_frame(f);
    // Wrong address on a one-byte frame: header error wins over short.
    f = {8'h00};
    queue_frame(f);
    // Wrong function code.
    f = {8'hFF, FC_WRITE};
    queue_frame(f);
    // Byte count not twice the word count.
    f = {8'hFF, FC_READ, 8'h04};
    queue_frame(f);
    // Clean header, frame ends early.
    f = {8'hFF, FC_READ, 8'h02, 8'hAB};
    queue_frame(f);
    // Full length, corrupted CRC high byte.
    f = {8'hFF, FC_READ, 8'h02, 8'h12, 8'h34};
    c = crc_of(f); f.push_back(c[7:0]); f.push_back(c[15:8] ^ 8'h80);
    queue_frame(f);
    settle();

    // Random part: phases of frames, each under its own settings and idle mix.
    first_bytes = bytes_sent;
    phase = 0;
    while (bytes_sent - first_bytes < RANDOM_BYTES) begin
      case (phase)
        0: configure(8'h00, 4'd8, 1'b0, octet_t'($urandom));
        1: configure(8'hFF, 4'd0, 1'b0, octet_t'($urandom));
        2: configure(octet_t'($urandom), 4'd15, 1'b0, octet_t'($urandom));
        3: configure(octet_t'($urandom), 4'($urandom), 1'b1, 8'h00);
        4: configure(8'h00, 4'($urandom), 1'b1, 8'hFF);
        5: configure(octet_t'($urandom), 4'd9, 1'b0, octet_t'($urandom));
        default: configure(octet_t'($urandom), 4'($urandom), ($urandom_range(9) < 3),
                           octet_t'($urandom));
      endcase
      // Rotate the idle mix: none, sender gaps, sink stalls, light both.
      case (phase % 4)
        0: begin send_gap_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_gap_pct <= 86; recv_stall_pct <= 0;  end
        2: begin send_gap_pct <= 0;  recv_stall_pct <= 86; end
        default: begin send_gap_pct <= 9; recv_stall_pct <= 9; end
      endcase
      repeat ($urandom_range(6, 12)) begin
        // Stop adding frames once the byte budget is spent.
        if (bytes_sent - first_bytes < RANDOM_BYTES) begin
          // Mostly well-formed replies with random content, the rest broken.
          if ($urandom_range(99) < 60) flaw = FR_GOOD;
          else flaw = frame_flaw_t'($urandom_range(FR_BAD_ADDR, FR_NOISE));
          make_frame(flaw);
        end
      end
      settle();
      phase++;
    end

    $display("Sent %0d frames (%0d bytes) under %0d register settings;",
             frames_sent, bytes_sent, settings_used);
    $display("checked %0d result transactions, %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
